### src/rpc_pkg.sv
// ----------------------------------------------------------------------------
// Reverse pair counter package
// Shared constants and the probe record that travels down the cell chain.
// ----------------------------------------------------------------------------
package rpc_pkg;

  // Capacity of the value store, one cell per stored value.
  localparam int MAX_ITEMS = 1024;

  localparam int VALUE_W    = 32;
  localparam int IDX_W      = (MAX_ITEMS > 2) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
  localparam int HIT_W      = IDX_W;
  localparam int PAIR_W     = 19;
  localparam int SUM_W      = ((HIT_W > PAIR_W) ? HIT_W : PAIR_W) + 1;
  localparam int OUT_DATA_W = ((PAIR_W + 7) / 8) * 8;

  localparam logic [PAIR_W-1:0] PAIR_MAX = {PAIR_W{1'b1}};
  localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(MAX_ITEMS);

  // A probe is one input value on its way past the stored values.
  // rem counts the cells still to compare against before the probe reaches
  // its own storage slot; done is set once it has been stored (or dropped).
  typedef struct packed {
    logic                      valid;
    logic                      last;
    logic                      drop;
    logic                      done;
    logic [IDX_W-1:0]          rem;
    logic [HIT_W-1:0]          hits;
    logic signed [VALUE_W-1:0] value;
  } probe_t;

endpackage

### src/rpc_cell.sv
// ----------------------------------------------------------------------------
// Reverse pair counter cell
// Holds one stored value, compares each passing probe against it and hands
// the probe on to the next cell.
// ----------------------------------------------------------------------------
module rpc_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  rpc_pkg::probe_t probe_i,
  output rpc_pkg::probe_t probe_o
);
  import rpc_pkg::*;

  logic signed [VALUE_W-1:0] held_q;
  probe_t                    probe_q;
  probe_t                    probe_d;
  logic signed [VALUE_W:0]   held_ext;
  logic signed [VALUE_W:0]   twice;
  logic                      cmp_en;
  logic                      store_en;
  logic                      hit;

  assign held_ext = {held_q[VALUE_W-1], held_q};
  assign twice    = {probe_i.value, 1'b0};

  // The value in this cell belongs to the current sequence exactly when the
  // probe still has cells left before its own slot.
  assign cmp_en   = probe_i.valid && !probe_i.done && (probe_i.rem != '0);
  assign store_en = probe_i.valid && !probe_i.done && (probe_i.rem == '0);
  assign hit      = cmp_en && (held_ext > twice);

  always_comb begin
    probe_d = probe_i;
    if (hit) begin
      probe_d.hits = probe_i.hits + HIT_W'(1);
    end
    if (cmp_en) begin
      probe_d.rem = probe_i.rem - IDX_W'(1);
    end
    if (store_en) begin
      probe_d.done = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && store_en) begin
      held_q <= probe_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else if (adv_i) begin
      probe_q <= probe_d;
    end
  end

  assign probe_o = probe_q;

endmodule

### src/rpc_collect.sv
// ----------------------------------------------------------------------------
// Reverse pair counter result collector
// Sums the hits of probes leaving the chain and registers the sequence total.
// ----------------------------------------------------------------------------
module rpc_collect (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  rpc_pkg::probe_t           probe_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [rpc_pkg::PAIR_W-1:0] pair_count_o,
  output logic                      overflowed_o
);
  import rpc_pkg::*;

  logic [PAIR_W-1:0] acc_q;
  logic [PAIR_W-1:0] acc_d;
  logic              ovf_q;
  logic              ovf_d;
  logic              out_valid_q;
  logic [PAIR_W-1:0] pair_q;
  logic              flag_q;
  logic [SUM_W-1:0]  sum;
  logic              take;

  assign take = adv_i && probe_i.valid;
  assign sum  = SUM_W'(acc_q) + SUM_W'(probe_i.hits);

  // The total saturates at the largest value the result field can carry.
  always_comb begin
    if (sum > SUM_W'(PAIR_MAX)) begin
      acc_d = PAIR_MAX;
    end else begin
      acc_d = sum[PAIR_W-1:0];
    end
    ovf_d = ovf_q || probe_i.drop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (take) begin
        if (probe_i.last) begin
          acc_q       <= '0;
          ovf_q       <= 1'b0;
          out_valid_q <= 1'b1;
        end else begin
          acc_q <= acc_d;
          ovf_q <= ovf_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && probe_i.last) begin
      pair_q <= acc_d;
      flag_q <= ovf_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pair_count_o = pair_q;
  assign overflowed_o = flag_q;

endmodule

### src/reverse_pair_counter_core.sv
// ----------------------------------------------------------------------------
// Reverse pair counter core
// Counts pairs i<j in a sequence where value[i] > 2 * value[j].
// ----------------------------------------------------------------------------
// Values stream in one per clock cycle unless input is held off, and each enters
// a chain of MAX_ITEMS cells. A value moves one cell per cycle while the chain
// advances, compares itself against the value held in every cell of its own
// sequence and is stored in the first free cell; so a new value can enter in
// every cycle and the sustained rate is one item per cycle unless the output
// stalls. The count for a sequence is registered in the collector once its last
// item leaves the chain. Input is held off only while a finished count waits on
// the output and the last item of the next sequence has reached the end of the
// chain. Items past MAX_ITEMS in one sequence are discarded and reported through
// the overflow flag in tuser; the item with tlast always ends the sequence.
// ----------------------------------------------------------------------------
module reverse_pair_counter_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rpc_pkg::VALUE_W-1:0]    s_axis_tdata,  // [31:0] value
  input  logic                          s_axis_tlast,  // last_item
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [rpc_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [18:0] pair_count, rest zero
  output logic                          m_axis_tuser   // overflowed
);
  import rpc_pkg::*;

  probe_t            chain [0:MAX_ITEMS];
  logic              adv;
  logic              accept;
  logic [CNT_W-1:0]  held_total_q;
  logic              full;
  logic [PAIR_W-1:0] pair_count;

  // The whole chain moves together unless the result register is occupied and
  // not being taken, and a finished sequence is about to leave the chain.
  assign adv = !(chain[MAX_ITEMS].valid && chain[MAX_ITEMS].last
                 && m_axis_tvalid && !m_axis_tready);

  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;
  assign full          = (held_total_q == FULL_CNT);

  always_comb begin
    chain[0]       = '0;
    chain[0].valid = accept;
    chain[0].last  = s_axis_tlast;
    chain[0].drop  = full;
    chain[0].done  = full;
    chain[0].rem   = held_total_q[IDX_W-1:0];
    chain[0].value = s_axis_tdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_total_q <= '0;
    end else if (accept) begin
      if (s_axis_tlast) begin
        held_total_q <= '0;
      end else if (!full) begin
        held_total_q <= held_total_q + CNT_W'(1);
      end
    end
  end

  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
    rpc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .probe_i (chain[k]),
      .probe_o (chain[k+1])
    );
  end

  rpc_collect u_collect (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .probe_i      (chain[MAX_ITEMS]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .pair_count_o (pair_count),
    .overflowed_o (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_DATA_W'(pair_count);

endmodule

### src/rpc_checker.sv
// ----------------------------------------------------------------------------
// Reverse pair counter port checker
// Watches the top-level ports and flags behavior the core must never show.
// ----------------------------------------------------------------------------
module rpc_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tready,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [rpc_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [18:0] pair_count, rest zero
  input  logic                          m_axis_tuser   // overflowed
);
  import rpc_pkg::*;

  // A stalled result keeps its contents until it is transferred.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A result only goes away through a transfer.
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(m_axis_tvalid) |-> $past(m_axis_tready))
    else $error("result withdrawn without transfer");

  // Input is only held off behind a stalled result.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

  // Padding bits above the count are always zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata >> PAIR_W) == '0)
    else $error("nonzero padding in result");

endmodule

bind reverse_pair_counter_core rpc_checker u_rpc_checker (.*);
